// File: hw/rtl/i2c_sensor_burst_read_sequencer_macros.svh
// ----------------------------------------------------------------------------
// I2C sensor burst read sequencer assertion macros
// Shared concurrent assertion forms, clocked on clock; ISBRS_ASSERT is qualified by reset.
// ----------------------------------------------------------------------------
`ifndef I2C_SENSOR_BURST_READ_SEQUENCER_MACROS_SVH
`define I2C_SENSOR_BURST_READ_SEQUENCER_MACROS_SVH

// Checked only while the block is out of reset.
`define ISBRS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define ISBRS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// File: hw/rtl/isbrs_pkg.sv
// ----------------------------------------------------------------------------
// I2C sensor burst read sequencer package
// Transfer types, bus command codes, event codes and the step plan.
// ----------------------------------------------------------------------------
package isbrs_pkg;

   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_START = 3'd1,
      CMD_WRITE = 3'd2,
      CMD_ACK   = 3'd3,
      CMD_NACK  = 3'd4,
      CMD_STOP  = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      OP_DONE    = 2'd0,
      OP_TIMEOUT = 2'd1,
      OP_BEGIN   = 2'd2
   } op_type;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] read_byte;
      logic       cycle_odd;
   } req_type;

   typedef struct packed {
      cmd_type    command;
      logic [7:0] command_byte;
      logic       capture_valid;
      logic [4:0] capture_slot;
      logic [7:0] capture_value;
      logic       error_flag;
   } rsp_type;

   localparam int unsigned ADDR_WIDTH = 5;

   localparam logic [2:0] REG_IMU_ADDRESS         = 3'd0;
   localparam logic [2:0] REG_IMU_FIRST_REGISTER  = 3'd1;
   localparam logic [2:0] REG_BARO0_ADDRESS       = 3'd2;
   localparam logic [2:0] REG_BARO1_ADDRESS       = 3'd3;
   localparam logic [2:0] REG_BARO_FIRST_REGISTER = 3'd4;

   localparam logic [6:0] IMU_ADDRESS_RESET         = 7'd104;
   localparam logic [7:0] IMU_FIRST_REGISTER_RESET  = 8'd59;
   localparam logic [6:0] BARO0_ADDRESS_RESET       = 7'd118;
   localparam logic [6:0] BARO1_ADDRESS_RESET       = 7'd119;
   localparam logic [7:0] BARO_FIRST_REGISTER_RESET = 8'd4;

   localparam logic [4:0] STEP_BEGIN          = 5'd0;
   localparam logic [4:0] STEP_IMU_WADDR      = 5'd1;
   localparam logic [4:0] STEP_IMU_REG        = 5'd2;
   localparam logic [4:0] STEP_IMU_RESTART    = 5'd3;
   localparam logic [4:0] STEP_IMU_RADDR      = 5'd4;
   localparam logic [4:0] STEP_IMU_CAP_FIRST  = 5'd6;
   localparam logic [4:0] STEP_IMU_NACK       = 5'd18;
   localparam logic [4:0] STEP_BARO_START     = 5'd19;
   localparam logic [4:0] STEP_BARO_WADDR     = 5'd20;
   localparam logic [4:0] STEP_BARO_REG       = 5'd21;
   localparam logic [4:0] STEP_BARO_RESTART   = 5'd22;
   localparam logic [4:0] STEP_BARO_RADDR     = 5'd23;
   localparam logic [4:0] STEP_BARO_CAP_FIRST = 5'd25;
   localparam logic [4:0] STEP_BARO_NACK      = 5'd29;
   localparam logic [4:0] STEP_STOP           = 5'd30;
   localparam logic [4:0] STEP_IDLE           = 5'd31;

   localparam logic [4:0] SLOT_BARO0_FIRST = 5'd14;
   localparam logic [4:0] SLOT_BARO1_FIRST = 5'd20;
   localparam logic [4:0] SLOT_LAST        = 5'd25;

endpackage

// File: hw/rtl/i2c_sensor_burst_read_sequencer.sv
// ----------------------------------------------------------------------------
// I2C sensor burst read sequencer
// Output: each accepted transfer's result is registered in the output buffer.
// Throughput: one input transfer per cycle while the output buffer is not full;
// a two-entry output buffer keeps input flowing while one result waits to be taken.
// Reset: step goes idle, the error flag clears, the output buffer empties
// and the configuration registers return to their default values.
// ----------------------------------------------------------------------------
`include "i2c_sensor_burst_read_sequencer_macros.svh"

module i2c_sensor_burst_read_sequencer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  isbrs_pkg::req_type                req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output isbrs_pkg::rsp_type                rsp_payload,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [isbrs_pkg::ADDR_WIDTH-1:0]  paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);
   import isbrs_pkg::*;

   logic [6:0] imu_address_ff;
   logic [7:0] imu_first_register_ff;
   logic [6:0] baro0_address_ff;
   logic [6:0] baro1_address_ff;
   logic [7:0] baro_first_register_ff;

   logic [4:0] step_ff;
   logic [4:0] step_in;
   logic       bus_error_ff;
   logic       bus_error_in;

   rsp_type    rsp_in;
   rsp_type    head_ff;
   rsp_type    skid_ff;
   logic [1:0] count_ff;

   logic       push;
   logic       pop;
   logic       csr_write;
   logic [2:0] csr_index;
   logic [6:0] baro_address;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;
   assign csr_index = paddr[ADDR_WIDTH-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         imu_address_ff         <= IMU_ADDRESS_RESET;
         imu_first_register_ff  <= IMU_FIRST_REGISTER_RESET;
         baro0_address_ff       <= BARO0_ADDRESS_RESET;
         baro1_address_ff       <= BARO1_ADDRESS_RESET;
         baro_first_register_ff <= BARO_FIRST_REGISTER_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_IMU_ADDRESS:         imu_address_ff         <= pwdata[6:0];
            REG_IMU_FIRST_REGISTER:  imu_first_register_ff  <= pwdata[7:0];
            REG_BARO0_ADDRESS:       baro0_address_ff       <= pwdata[6:0];
            REG_BARO1_ADDRESS:       baro1_address_ff       <= pwdata[6:0];
            REG_BARO_FIRST_REGISTER: baro_first_register_ff <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_IMU_ADDRESS:         prdata = {25'd0, imu_address_ff};
         REG_IMU_FIRST_REGISTER:  prdata = {24'd0, imu_first_register_ff};
         REG_BARO0_ADDRESS:       prdata = {25'd0, baro0_address_ff};
         REG_BARO1_ADDRESS:       prdata = {25'd0, baro1_address_ff};
         REG_BARO_FIRST_REGISTER: prdata = {24'd0, baro_first_register_ff};
         default:                 prdata = 32'd0;
      endcase
   end

   assign baro_address = req_payload.cycle_odd ? baro1_address_ff : baro0_address_ff;

   always_comb begin
      rsp_in       = '0;
      step_in      = step_ff;
      bus_error_in = bus_error_ff;
      unique case (req_payload.op)
         OP_TIMEOUT: begin
            rsp_in.command = CMD_STOP;
            bus_error_in   = 1'b1;
         end
         OP_BEGIN: begin
            step_in = STEP_BEGIN;
         end
         OP_DONE: begin
            if (step_ff != STEP_IDLE) begin
               if (step_ff >= STEP_IMU_CAP_FIRST && step_ff <= STEP_BARO_START) begin
                  rsp_in.capture_valid = 1'b1;
                  rsp_in.capture_slot  = step_ff - STEP_IMU_CAP_FIRST;
                  rsp_in.capture_value = req_payload.read_byte;
               end else if (step_ff >= STEP_BARO_CAP_FIRST && step_ff <= STEP_STOP) begin
                  rsp_in.capture_valid = 1'b1;
                  rsp_in.capture_slot  = (req_payload.cycle_odd ? SLOT_BARO1_FIRST
                                                                : SLOT_BARO0_FIRST)
                                         + (step_ff - STEP_BARO_CAP_FIRST);
                  rsp_in.capture_value = req_payload.read_byte;
               end
               unique case (step_ff)
                  STEP_BEGIN, STEP_IMU_RESTART, STEP_BARO_START, STEP_BARO_RESTART: begin
                     rsp_in.command = CMD_START;
                  end
                  STEP_IMU_WADDR: begin
                     bus_error_in        = 1'b0;
                     rsp_in.command      = CMD_WRITE;
                     rsp_in.command_byte = {imu_address_ff, 1'b0};
                  end
                  STEP_IMU_REG: begin
                     rsp_in.command      = CMD_WRITE;
                     rsp_in.command_byte = imu_first_register_ff;
                  end
                  STEP_IMU_RADDR: begin
                     rsp_in.command      = CMD_WRITE;
                     rsp_in.command_byte = {imu_address_ff, 1'b1};
                  end
                  STEP_BARO_WADDR: begin
                     rsp_in.command      = CMD_WRITE;
                     rsp_in.command_byte = {baro_address, 1'b0};
                  end
                  STEP_BARO_REG: begin
                     rsp_in.command      = CMD_WRITE;
                     rsp_in.command_byte = baro_first_register_ff;
                  end
                  STEP_BARO_RADDR: begin
                     rsp_in.command      = CMD_WRITE;
                     rsp_in.command_byte = {baro_address, 1'b1};
                  end
                  STEP_IMU_NACK, STEP_BARO_NACK: begin
                     rsp_in.command = CMD_NACK;
                  end
                  STEP_STOP: begin
                     rsp_in.command = CMD_STOP;
                  end
                  default: begin
                     rsp_in.command = CMD_ACK;
                  end
               endcase
               step_in = step_ff + 5'd1;
            end
         end
         default: ;
      endcase
      rsp_in.error_flag = bus_error_in;
   end

   assign req_stall   = (count_ff == 2'd2);
   assign rsp_valid   = (count_ff != 2'd0);
   assign rsp_payload = head_ff;
   assign push        = req_valid & ~req_stall;
   assign pop         = rsp_valid & ~rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_IDLE;
         bus_error_ff <= 1'b0;
         count_ff     <= 2'd0;
      end else begin
         if (push) begin
            step_ff      <= step_in;
            bus_error_ff <= bus_error_in;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if ((count_ff == 2'd0 && push) || (count_ff == 2'd1 && push && pop)) begin
         head_ff <= rsp_in;
      end else if (count_ff == 2'd2 && pop) begin
         head_ff <= skid_ff;
      end
      if (count_ff == 2'd1 && push && !pop) begin
         skid_ff <= rsp_in;
      end
   end

   `ISBRS_ASSERT_ALWAYS(a_reset_empties, reset |=> !rsp_valid, "output buffer not empty after reset")
   `ISBRS_ASSERT(a_slot_range, rsp_valid && rsp_payload.capture_valid |-> rsp_payload.capture_slot <= SLOT_LAST, "capture slot out of range")
   `ISBRS_ASSERT(a_begin_step, push && req_payload.op == OP_BEGIN |=> step_ff == STEP_BEGIN, "begin did not reset the step")
   `ISBRS_ASSERT(a_timeout_error, push && req_payload.op == OP_TIMEOUT |=> bus_error_ff, "timeout did not set the error flag")
   `ISBRS_ASSERT(a_idle_holds, push && req_payload.op == OP_DONE && step_ff == STEP_IDLE |=> step_ff == STEP_IDLE, "idle step advanced on done")

endmodule
